// File: design/zcpp_pkg.sv
package zcpp_pkg;

   localparam int TIME_W    = 21;
   localparam int ELEV_W    = 24;
   localparam int FRAC_BITS = 16;

   // time and elevation differences
   localparam int DT_W = TIME_W + 1;
   localparam int DE_W = ELEV_W + 1;

   // shared add/sub unit and sequencer widths
   localparam int ACC_W     = 69;
   localparam int MC_W      = 68;
   localparam int MPL_W     = DE_W;
   localparam int MUL_STEPS = MPL_W;
   localparam int NUM_W     = ACC_W - 1;
   localparam int DIV_W     = 48;
   localparam int QUO_W     = 41;
   localparam int CNT_W     = 7;

   localparam logic [TIME_W-1:0] TIME_MAX    = '1;
   localparam longint            HOURS_LIMIT = longint'(24) << FRAC_BITS;
   localparam logic [TIME_W-1:0] PEAK_LIMIT  =
      (HOURS_LIMIT > longint'(TIME_MAX)) ? TIME_MAX : TIME_W'(HOURS_LIMIT);
   localparam logic [QUO_W-1:0]  OFFSET_CAP  = QUO_W'(1) << (QUO_W - 1);

   typedef struct packed {
      logic                     rise_flag;
      logic [TIME_W-1:0]        rise_stamp;
      logic                     set_flag;
      logic [TIME_W-1:0]        set_stamp;
      logic [TIME_W-1:0]        max_time;
      logic signed [ELEV_W-1:0] max_elev;
      logic                     before_valid;
      logic [TIME_W-1:0]        before_time;
      logic signed [ELEV_W-1:0] before_elev;
      logic                     after_valid;
      logic [TIME_W-1:0]        after_time;
      logic signed [ELEV_W-1:0] after_elev;
   } snap_type;

   typedef struct packed {
      logic              rise_found;
      logic [TIME_W-1:0] rise_time;
      logic              set_found;
      logic [TIME_W-1:0] set_time;
      logic [TIME_W-1:0] peak_time;
      logic              peak_refined;
   } result_type;

endpackage

// File: design/zcpp_addsub.sv
module zcpp_addsub (
   input  logic [zcpp_pkg::ACC_W-1:0] op_a,
   input  logic [zcpp_pkg::ACC_W-1:0] op_b,
   input  logic                       op_sub,
   output logic [zcpp_pkg::ACC_W-1:0] sum
);

   assign sum = op_a + (op_sub ? ~op_b : op_b) + zcpp_pkg::ACC_W'(op_sub);

endmodule

// File: design/zcpp_scan.sv
module zcpp_scan (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [zcpp_pkg::TIME_W-1:0]        time_hours,
   input  logic signed [zcpp_pkg::ELEV_W-1:0] elevation_sample,
   input  logic                               last_sample,
   output zcpp_pkg::snap_type                 snap
);

   logic                               seen_first_ff, seen_first_in;
   logic signed [zcpp_pkg::ELEV_W-1:0] prior_elev_ff, prior_elev_in;
   logic [zcpp_pkg::TIME_W-1:0]        prior_time_ff, prior_time_in;
   logic                               rise_flag_ff, rise_flag_in;
   logic [zcpp_pkg::TIME_W-1:0]        rise_stamp_ff, rise_stamp_in;
   logic                               set_flag_ff, set_flag_in;
   logic [zcpp_pkg::TIME_W-1:0]        set_stamp_ff, set_stamp_in;
   logic signed [zcpp_pkg::ELEV_W-1:0] max_elev_ff, max_elev_in;
   logic [zcpp_pkg::TIME_W-1:0]        max_time_ff, max_time_in;
   logic                               before_valid_ff, before_valid_in;
   logic [zcpp_pkg::TIME_W-1:0]        before_time_ff, before_time_in;
   logic signed [zcpp_pkg::ELEV_W-1:0] before_elev_ff, before_elev_in;
   logic                               after_valid_ff, after_valid_in;
   logic [zcpp_pkg::TIME_W-1:0]        after_time_ff, after_time_in;
   logic signed [zcpp_pkg::ELEV_W-1:0] after_elev_ff, after_elev_in;

   logic prior_neg;
   logic cur_neg;

   assign prior_neg = prior_elev_ff[zcpp_pkg::ELEV_W-1];
   assign cur_neg   = elevation_sample[zcpp_pkg::ELEV_W-1];

   always_comb begin
      seen_first_in   = seen_first_ff;
      prior_elev_in   = prior_elev_ff;
      prior_time_in   = prior_time_ff;
      rise_flag_in    = rise_flag_ff;
      rise_stamp_in   = rise_stamp_ff;
      set_flag_in     = set_flag_ff;
      set_stamp_in    = set_stamp_ff;
      max_elev_in     = max_elev_ff;
      max_time_in     = max_time_ff;
      before_valid_in = before_valid_ff;
      before_time_in  = before_time_ff;
      before_elev_in  = before_elev_ff;
      after_valid_in  = after_valid_ff;
      after_time_in   = after_time_ff;
      after_elev_in   = after_elev_ff;
      if (accept) begin
         if (!seen_first_ff) begin
            seen_first_in   = 1'b1;
            max_elev_in     = elevation_sample;
            max_time_in     = time_hours;
            before_valid_in = 1'b0;
            after_valid_in  = 1'b0;
         end else begin
            if (elevation_sample > max_elev_ff) begin
               before_time_in  = prior_time_ff;
               before_elev_in  = prior_elev_ff;
               before_valid_in = 1'b1;
               max_elev_in     = elevation_sample;
               max_time_in     = time_hours;
               after_valid_in  = 1'b0;
            end else if (!after_valid_ff) begin
               after_time_in  = time_hours;
               after_elev_in  = elevation_sample;
               after_valid_in = 1'b1;
            end
            if (!rise_flag_ff && prior_neg && !cur_neg) begin
               rise_flag_in  = 1'b1;
               rise_stamp_in = time_hours;
            end
            if (!set_flag_ff && !prior_neg && cur_neg) begin
               set_flag_in  = 1'b1;
               set_stamp_in = time_hours;
            end
         end
         prior_elev_in = elevation_sample;
         prior_time_in = time_hours;
      end
   end

   // run state as it stands after this item
   always_comb begin
      snap.rise_flag    = rise_flag_in;
      snap.rise_stamp   = rise_stamp_in;
      snap.set_flag     = set_flag_in;
      snap.set_stamp    = set_stamp_in;
      snap.max_time     = max_time_in;
      snap.max_elev     = max_elev_in;
      snap.before_valid = before_valid_in;
      snap.before_time  = before_time_in;
      snap.before_elev  = before_elev_in;
      snap.after_valid  = after_valid_in;
      snap.after_time   = after_time_in;
      snap.after_elev   = after_elev_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && last_sample)) begin
         seen_first_ff   <= 1'b0;
         rise_flag_ff    <= 1'b0;
         set_flag_ff     <= 1'b0;
         before_valid_ff <= 1'b0;
         after_valid_ff  <= 1'b0;
         rise_stamp_ff   <= '0;
         set_stamp_ff    <= '0;
      end else begin
         seen_first_ff   <= seen_first_in;
         rise_flag_ff    <= rise_flag_in;
         set_flag_ff     <= set_flag_in;
         before_valid_ff <= before_valid_in;
         after_valid_ff  <= after_valid_in;
         rise_stamp_ff   <= rise_stamp_in;
         set_stamp_ff    <= set_stamp_in;
      end
      prior_elev_ff  <= prior_elev_in;
      prior_time_ff  <= prior_time_in;
      max_elev_ff    <= max_elev_in;
      max_time_ff    <= max_time_in;
      before_time_ff <= before_time_in;
      before_elev_ff <= before_elev_in;
      after_time_ff  <= after_time_in;
      after_elev_ff  <= after_elev_in;
   end

endmodule

// File: design/zcpp_vertex.sv
module zcpp_vertex (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  zcpp_pkg::snap_type   snap,
   output logic                 idle,
   output logic                 done,
   input  logic                 taken,
   output zcpp_pkg::result_type result
);

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0000000000001,
      ST_CHECK   = 13'b0000000000010,
      ST_DEN_A   = 13'b0000000000100,
      ST_DEN_B   = 13'b0000000001000,
      ST_DEN_FIX = 13'b0000000010000,
      ST_SQ1     = 13'b0000000100000,
      ST_NUM_A   = 13'b0000001000000,
      ST_SQ2     = 13'b0000010000000,
      ST_NUM_B   = 13'b0000100000000,
      ST_NUM_FIX = 13'b0001000000000,
      ST_DIVIDE  = 13'b0010000000000,
      ST_VERTEX  = 13'b0100000000000,
      ST_DONE    = 13'b1000000000000
   } state_type;

   state_type                          state_ff, state_in;
   zcpp_pkg::snap_type                 snap_ff, snap_in;
   logic [zcpp_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [zcpp_pkg::ACC_W-1:0]         acc_ff, acc_in;
   logic [zcpp_pkg::MC_W-1:0]          mcand_ff, mcand_in;
   logic [zcpp_pkg::MPL_W-1:0]         mplier_ff, mplier_in;
   logic                               sub_ff, sub_in;
   logic [zcpp_pkg::ACC_W-1:0]         num_ff, num_in;
   logic [zcpp_pkg::DIV_W-1:0]         dmag_ff, dmag_in;
   logic                               den_neg_ff, den_neg_in;
   logic                               num_neg_ff, num_neg_in;
   logic [zcpp_pkg::QUO_W-1:0]         quo_ff, quo_in;
   logic                               over_ff, over_in;
   logic [zcpp_pkg::TIME_W-1:0]        peak_ff, peak_in;
   logic                               refined_ff, refined_in;

   logic signed [zcpp_pkg::DT_W-1:0]   d1, d2;
   logic signed [zcpp_pkg::DE_W-1:0]   g0, g2;
   logic [zcpp_pkg::DT_W-1:0]          d1_mag, d2_mag;
   logic [zcpp_pkg::DE_W-1:0]          g0_mag, g2_mag;
   logic                               usable;
   logic                               mul_phase;
   logic                               mul_last;
   logic [zcpp_pkg::ACC_W-1:0]         op_a, op_b, sum;
   logic                               op_sub;
   logic [zcpp_pkg::ACC_W-1:0]         step_acc;
   logic [zcpp_pkg::ACC_W-1:0]         abs_acc;
   logic [zcpp_pkg::ACC_W-1:0]         div_shift;
   logic [zcpp_pkg::QUO_W-1:0]         offset;

   zcpp_addsub u_addsub (
      .op_a   (op_a),
      .op_b   (op_b),
      .op_sub (op_sub),
      .sum    (sum)
   );

   // parabola terms around the maximum
   assign d1 = $signed({1'b0, snap_ff.max_time}) - $signed({1'b0, snap_ff.before_time});
   assign d2 = $signed({1'b0, snap_ff.max_time}) - $signed({1'b0, snap_ff.after_time});
   assign g0 = $signed({snap_ff.max_elev[zcpp_pkg::ELEV_W-1], snap_ff.max_elev})
             - $signed({snap_ff.before_elev[zcpp_pkg::ELEV_W-1], snap_ff.before_elev});
   assign g2 = $signed({snap_ff.max_elev[zcpp_pkg::ELEV_W-1], snap_ff.max_elev})
             - $signed({snap_ff.after_elev[zcpp_pkg::ELEV_W-1], snap_ff.after_elev});

   assign d1_mag = d1[zcpp_pkg::DT_W-1] ? -d1 : d1;
   assign d2_mag = d2[zcpp_pkg::DT_W-1] ? -d2 : d2;
   assign g0_mag = g0[zcpp_pkg::DE_W-1] ? -g0 : g0;
   assign g2_mag = g2[zcpp_pkg::DE_W-1] ? -g2 : g2;

   assign usable = snap_ff.before_valid && snap_ff.after_valid
                && (snap_ff.before_time != snap_ff.max_time)
                && (snap_ff.max_time != snap_ff.after_time)
                && (snap_ff.before_time != snap_ff.after_time);

   assign mul_phase = (state_ff == ST_DEN_A) || (state_ff == ST_DEN_B)
                   || (state_ff == ST_SQ1) || (state_ff == ST_NUM_A)
                   || (state_ff == ST_SQ2) || (state_ff == ST_NUM_B);
   assign mul_last  = cnt_ff == zcpp_pkg::CNT_W'(zcpp_pkg::MUL_STEPS - 1);

   assign step_acc  = mplier_ff[0] ? sum : acc_ff;
   assign abs_acc   = acc_ff[zcpp_pkg::ACC_W-1] ? sum : acc_ff;
   assign div_shift = {acc_ff[zcpp_pkg::ACC_W-2:0], num_ff[zcpp_pkg::NUM_W-1]};
   assign offset    = (over_ff || (quo_ff > zcpp_pkg::OFFSET_CAP)) ?
                      zcpp_pkg::OFFSET_CAP : quo_ff;

   // operand select for the shared add/sub unit
   always_comb begin
      unique case (state_ff)
         ST_DIVIDE: begin
            op_a   = div_shift;
            op_b   = zcpp_pkg::ACC_W'(dmag_ff);
            op_sub = 1'b1;
         end
         ST_VERTEX: begin
            op_a   = zcpp_pkg::ACC_W'(snap_ff.max_time);
            op_b   = zcpp_pkg::ACC_W'(offset);
            op_sub = (num_neg_ff == den_neg_ff);
         end
         ST_DEN_FIX, ST_NUM_FIX: begin
            op_a   = '0;
            op_b   = acc_ff;
            op_sub = 1'b1;
         end
         default: begin
            op_a   = acc_ff;
            op_b   = zcpp_pkg::ACC_W'(mcand_ff);
            op_sub = sub_ff;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      snap_in    = snap_ff;
      cnt_in     = cnt_ff;
      acc_in     = acc_ff;
      mcand_in   = mcand_ff;
      mplier_in  = mplier_ff;
      sub_in     = sub_ff;
      num_in     = num_ff;
      dmag_in    = dmag_ff;
      den_neg_in = den_neg_ff;
      num_neg_in = num_neg_ff;
      quo_in     = quo_ff;
      over_in    = over_ff;
      peak_in    = peak_ff;
      refined_in = refined_ff;

      // one shift-add step of the multiplier
      if (mul_phase) begin
         acc_in    = step_acc;
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               snap_in  = snap;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!usable) begin
               peak_in    = snap_ff.max_time;
               refined_in = 1'b0;
               state_in   = ST_DONE;
            end else begin
               acc_in    = '0;
               mcand_in  = zcpp_pkg::MC_W'(d1_mag);
               mplier_in = zcpp_pkg::MPL_W'(g2_mag);
               sub_in    = d1[zcpp_pkg::DT_W-1] ^ g2[zcpp_pkg::DE_W-1];
               cnt_in    = '0;
               state_in  = ST_DEN_A;
            end
         end
         ST_DEN_A: begin
            if (mul_last) begin
               mcand_in  = zcpp_pkg::MC_W'(d2_mag);
               mplier_in = zcpp_pkg::MPL_W'(g0_mag);
               sub_in    = !(d2[zcpp_pkg::DT_W-1] ^ g0[zcpp_pkg::DE_W-1]);
               cnt_in    = '0;
               state_in  = ST_DEN_B;
            end
         end
         ST_DEN_B: begin
            if (mul_last) begin
               state_in = ST_DEN_FIX;
            end
         end
         ST_DEN_FIX: begin
            if (acc_ff == '0) begin
               peak_in    = snap_ff.max_time;
               refined_in = 1'b0;
               state_in   = ST_DONE;
            end else begin
               den_neg_in = acc_ff[zcpp_pkg::ACC_W-1];
               dmag_in    = {abs_acc[zcpp_pkg::DIV_W-2:0], 1'b0};
               acc_in     = '0;
               mcand_in   = zcpp_pkg::MC_W'(d1_mag);
               mplier_in  = zcpp_pkg::MPL_W'(d1_mag);
               sub_in     = 1'b0;
               cnt_in     = '0;
               state_in   = ST_SQ1;
            end
         end
         ST_SQ1: begin
            if (mul_last) begin
               acc_in    = '0;
               mcand_in  = step_acc[zcpp_pkg::MC_W-1:0];
               mplier_in = zcpp_pkg::MPL_W'(g2_mag);
               sub_in    = g2[zcpp_pkg::DE_W-1];
               cnt_in    = '0;
               state_in  = ST_NUM_A;
            end
         end
         ST_NUM_A: begin
            if (mul_last) begin
               num_in    = step_acc;
               acc_in    = '0;
               mcand_in  = zcpp_pkg::MC_W'(d2_mag);
               mplier_in = zcpp_pkg::MPL_W'(d2_mag);
               sub_in    = 1'b0;
               cnt_in    = '0;
               state_in  = ST_SQ2;
            end
         end
         ST_SQ2: begin
            if (mul_last) begin
               acc_in    = num_ff;
               mcand_in  = step_acc[zcpp_pkg::MC_W-1:0];
               mplier_in = zcpp_pkg::MPL_W'(g0_mag);
               sub_in    = !g0[zcpp_pkg::DE_W-1];
               cnt_in    = '0;
               state_in  = ST_NUM_B;
            end
         end
         ST_NUM_B: begin
            if (mul_last) begin
               state_in = ST_NUM_FIX;
            end
         end
         ST_NUM_FIX: begin
            num_neg_in = acc_ff[zcpp_pkg::ACC_W-1];
            num_in     = zcpp_pkg::ACC_W'(abs_acc[zcpp_pkg::NUM_W-1:0]);
            acc_in     = '0;
            quo_in     = '0;
            over_in    = 1'b0;
            cnt_in     = '0;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // restoring division, one quotient bit per cycle
            acc_in  = sum[zcpp_pkg::ACC_W-1] ? div_shift : sum;
            quo_in  = {quo_ff[zcpp_pkg::QUO_W-2:0], !sum[zcpp_pkg::ACC_W-1]};
            over_in = over_ff | quo_ff[zcpp_pkg::QUO_W-1];
            num_in  = num_ff << 1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == zcpp_pkg::CNT_W'(zcpp_pkg::NUM_W - 1)) begin
               state_in = ST_VERTEX;
            end
         end
         ST_VERTEX: begin
            priority if (sum[zcpp_pkg::ACC_W-1]) begin
               peak_in = '0;
            end else if (sum > zcpp_pkg::ACC_W'(zcpp_pkg::PEAK_LIMIT)) begin
               peak_in = zcpp_pkg::PEAK_LIMIT;
            end else begin
               peak_in = sum[zcpp_pkg::TIME_W-1:0];
            end
            refined_in = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      snap_ff    <= snap_in;
      cnt_ff     <= cnt_in;
      acc_ff     <= acc_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      sub_ff     <= sub_in;
      num_ff     <= num_in;
      dmag_ff    <= dmag_in;
      den_neg_ff <= den_neg_in;
      num_neg_ff <= num_neg_in;
      quo_ff     <= quo_in;
      over_ff    <= over_in;
      peak_ff    <= peak_in;
      refined_ff <= refined_in;
   end

   assign idle = (state_ff == ST_IDLE);
   assign done = (state_ff == ST_DONE);

   always_comb begin
      result.rise_found   = snap_ff.rise_flag;
      result.rise_time    = snap_ff.rise_flag ? snap_ff.rise_stamp : '0;
      result.set_found    = snap_ff.set_flag;
      result.set_time     = snap_ff.set_flag ? snap_ff.set_stamp : '0;
      result.peak_time    = peak_ff;
      result.peak_refined = refined_ff;
   end

endmodule

// File: design/zero_cross_peak_parabolic_top.sv
// an item without the last mark updates the registered run state and gives no result
// last item: with no vertex formed the result follows the check alone, with a zero vertex
// denominator it follows two products, else six 25-step shift-add products and a 68-step divide
// throughput: one item per cycle within a run; after a last item input waits for the peak unit
// reset: synchronous active high, clears the run state, the peak unit and the output register
module zero_cross_peak_parabolic_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [zcpp_pkg::TIME_W-1:0]        req_time_hours,
   input  logic signed [zcpp_pkg::ELEV_W-1:0] req_elevation_sample,
   input  logic                               req_last_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_rise_found,
   output logic [zcpp_pkg::TIME_W-1:0]        rsp_rise_time,
   output logic                               rsp_set_found,
   output logic [zcpp_pkg::TIME_W-1:0]        rsp_set_time,
   output logic [zcpp_pkg::TIME_W-1:0]        rsp_peak_time,
   output logic                               rsp_peak_refined
);

   logic                 accept;
   logic                 engine_idle;
   logic                 engine_done;
   logic                 load;
   zcpp_pkg::snap_type   snap;
   zcpp_pkg::result_type engine_result;

   logic                 rsp_valid_ff, rsp_valid_in;
   zcpp_pkg::result_type rsp_result_ff, rsp_result_in;

   assign req_ready = engine_idle;
   assign accept    = req_valid && req_ready;

   zcpp_scan u_scan (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .time_hours       (req_time_hours),
      .elevation_sample (req_elevation_sample),
      .last_sample      (req_last_sample),
      .snap             (snap)
   );

   zcpp_vertex u_vertex (
      .clock  (clock),
      .reset  (reset),
      .start  (accept && req_last_sample),
      .snap   (snap),
      .idle   (engine_idle),
      .done   (engine_done),
      .taken  (load),
      .result (engine_result)
   );

   // output register
   assign load = engine_done && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_result_in = rsp_result_ff;
      priority if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = engine_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rise_found   = rsp_result_ff.rise_found;
   assign rsp_rise_time    = rsp_result_ff.rise_time;
   assign rsp_set_found    = rsp_result_ff.set_found;
   assign rsp_set_time     = rsp_result_ff.set_time;
   assign rsp_peak_time    = rsp_result_ff.peak_time;
   assign rsp_peak_refined = rsp_result_ff.peak_refined;

endmodule
